// ===== hw/rtl/olidf_pkg.sv =====
// Shared types and constants for the ordered list core.
// No dependencies; used by olidf_cell and ordered_list_insert_delete_find_core.
`default_nettype none

package olidf_pkg;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_FIND   = 2'd2;

    localparam int POS_W = 5;

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } t_state;

    // per-cell controls, one set for each list slot
    typedef struct packed {
        logic shift_up;    // take left neighbor's word (insert)
        logic load;        // take the key word (insert target)
        logic shift_down;  // take right neighbor's word (delete)
        logic cmp;         // latch key match
        logic hit_shift;   // take right neighbor's match flag (find scan)
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/olidf_cell.sv =====
// One list slot: a 32-bit word plus a match flag, linked to both neighbors.
// Depends on olidf_pkg for the control struct.
`default_nettype none

module olidf_cell (
    input  wire                  i_clk,
    input  wire olidf_pkg::t_cell_ctl i_ctl,
    input  wire  [31:0]          i_key,
    input  wire  [31:0]          i_left_data,
    input  wire  [31:0]          i_right_data,
    input  wire                  i_right_hit,
    output logic [31:0]          o_data,
    output logic                 o_hit
);

    logic [31:0] r_data;
    logic        r_hit;

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.shift_up) begin
            r_data <= i_left_data;
        end else if (i_ctl.load) begin
            r_data <= i_key;
        end else if (i_ctl.shift_down) begin
            r_data <= i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.cmp) begin
            r_hit <= (r_data == i_key);
        end else if (i_ctl.hit_shift) begin
            r_hit <= i_right_hit;
        end
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule

`default_nettype wire

// ===== hw/rtl/ordered_list_insert_delete_find_core.sv =====
// Ordered list core: insert, delete and find over a chain of CAPACITY slots.
// Insert and delete: result strobe the cycle after the transaction, one per cycle while not busy.
// Find: slots latch key matches, then match flags shift toward slot 0 one step a
// cycle; busy high during the scan.
// Synchronous active-low reset empties the list; slot words are not cleared.
// o_done pulses for one cycle; the receiver cannot stall the core.
`default_nettype none

module ordered_list_insert_delete_find_core #(
    parameter int CAPACITY = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire  [1:0]         i_mode,
    input  wire  [4:0]         i_position,
    input  wire  signed [31:0] i_value,
    output logic               o_done,
    output logic               o_ok,
    output logic signed [31:0] o_removed_value,
    output logic [4:0]         o_found_position,
    output logic [4:0]         o_list_length
);

    // count width holds 0..CAPACITY; XW compares positions, counts and indexes
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > olidf_pkg::POS_W) ? CW : olidf_pkg::POS_W) + 1;
    // only slots reachable by a 5-bit position can be deleted
    localparam int RD = (CAPACITY < 31) ? CAPACITY : 31;

    olidf_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_scan, n_scan;

    logic          r_done, n_done;
    logic          r_ok, n_ok;
    logic [31:0]   r_removed, n_removed;
    logic [4:0]    r_found, n_found;

    olidf_pkg::t_cell_ctl w_ctl [CAPACITY];
    logic [31:0]          w_data [CAPACITY];
    logic                 w_hit  [CAPACITY];

    logic          w_accept;
    logic [XW-1:0] w_pos_x, w_cnt_x, w_scan_x, w_found_x;
    logic          w_ins_ok, w_del_ok, w_scan_end;
    logic [31:0]   w_del_word;

    assign busy     = (r_state == olidf_pkg::S_SCAN);
    assign w_accept = start && !busy;

    assign w_pos_x   = XW'(i_position);
    assign w_cnt_x   = XW'(r_count);
    assign w_scan_x  = XW'(r_scan);
    assign w_found_x = w_scan_x + XW'(1);

    // insert allows append at length+1, refused when full
    assign w_ins_ok = (w_pos_x != '0) && (w_pos_x <= w_cnt_x + XW'(1))
                   && (w_cnt_x < XW'(CAPACITY));
    assign w_del_ok = (w_pos_x != '0) && (w_pos_x <= w_cnt_x);

    // scan is over once every held slot has been looked at
    assign w_scan_end = (r_scan == r_count);

    // word leaving on delete: and-or select over addressable slots
    always_comb begin
        w_del_word = '0;
        for (int k = 0; k < RD; k++) begin
            if (w_pos_x == XW'(k + 1)) begin
                w_del_word = w_del_word | w_data[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            olidf_pkg::S_IDLE: begin
                if (w_accept && (i_mode == olidf_pkg::MODE_FIND)) begin
                    n_state = olidf_pkg::S_SCAN;
                end
            end
            olidf_pkg::S_SCAN: begin
                if (w_scan_end || w_hit[0]) begin
                    n_state = olidf_pkg::S_IDLE;
                end
            end
            default: n_state = olidf_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // outputs: slot controls, count, scan index, result registers
    // ---------------------------------------------------------------
    always_comb begin
        n_count   = r_count;
        n_scan    = r_scan;
        n_done    = 1'b0;
        n_ok      = 1'b0;
        n_removed = '0;
        n_found   = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_ctl[i] = '0;
        end

        unique case (r_state)
            olidf_pkg::S_IDLE: begin
                if (w_accept) begin
                    priority if (i_mode == olidf_pkg::MODE_INSERT) begin
                        n_done = 1'b1;
                        n_ok   = w_ins_ok;
                        if (w_ins_ok) begin
                            n_count = r_count + CW'(1);
                            for (int i = 0; i < CAPACITY; i++) begin
                                // slot i holds position i+1
                                w_ctl[i].load     = (XW'(i + 1) == w_pos_x);
                                w_ctl[i].shift_up = (XW'(i + 1) >  w_pos_x);
                            end
                        end
                    end else if (i_mode == olidf_pkg::MODE_DELETE) begin
                        n_done = 1'b1;
                        n_ok   = w_del_ok;
                        if (w_del_ok) begin
                            n_count   = r_count - CW'(1);
                            n_removed = w_del_word;
                            for (int i = 0; i < CAPACITY; i++) begin
                                w_ctl[i].shift_down = (XW'(i + 1) >= w_pos_x);
                            end
                        end
                    end else if (i_mode == olidf_pkg::MODE_FIND) begin
                        n_scan = '0;
                        for (int i = 0; i < CAPACITY; i++) begin
                            w_ctl[i].cmp = 1'b1;
                        end
                    end else begin
                        // unused mode: plain refusal
                        n_done = 1'b1;
                    end
                end
            end
            olidf_pkg::S_SCAN: begin
                priority if (w_scan_end) begin
                    n_done = 1'b1;
                end else if (w_hit[0]) begin
                    n_done  = 1'b1;
                    n_ok    = 1'b1;
                    n_found = w_found_x[4:0];
                end else begin
                    n_scan = r_scan + CW'(1);
                    for (int i = 0; i < CAPACITY; i++) begin
                        w_ctl[i].hit_shift = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= olidf_pkg::S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan    <= n_scan;
        r_ok      <= n_ok;
        r_removed <= n_removed;
        r_found   <= n_found;
    end

    // ---------------------------------------------------------------
    // slot chain: data moves up/down one slot, match flags move down
    // ---------------------------------------------------------------
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [31:0] w_left, w_right;
        logic        w_rhit;
        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
            assign w_rhit  = 1'b0;
        end else begin : g_inner
            assign w_right = w_data[g+1];
            assign w_rhit  = w_hit[g+1];
        end
        olidf_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl[g]),
            .i_key        (i_value),
            .i_left_data  (w_left),
            .i_right_data (w_right),
            .i_right_hit  (w_rhit),
            .o_data       (w_data[g]),
            .o_hit        (w_hit[g])
        );
    end

    assign o_done           = r_done;
    assign o_ok             = r_ok;
    assign o_removed_value  = r_removed;
    assign o_found_position = r_found;
    assign o_list_length    = w_cnt_x[4:0];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list count above capacity");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == olidf_pkg::S_SCAN) |-> (r_scan <= r_count))
        else $error("find scan ran past list length");

    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode != olidf_pkg::MODE_FIND)) |=> o_done)
        else $error("insert/delete transaction gave no result");

    a_find_no_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == olidf_pkg::S_SCAN) |=> (o_removed_value == '0))
        else $error("find result carries a removed value");
`endif

endmodule

`default_nettype wire
